### design/snhm_pkg.sv
// ----------------------------------------------------------------------------
// snhm_pkg
// Shared types, constants and Q16.16 helpers for the spring network
// Hessian product unit.
// ----------------------------------------------------------------------------
package snhm_pkg;

    localparam int MAX_NODES   = 256;
    localparam int MAX_SPRINGS = 1024;
    localparam int AXES        = 3;
    localparam int VEC_LEN     = AXES * MAX_NODES;
    localparam int VEC_AW      = $clog2(VEC_LEN);
    localparam int SPR_AW      = $clog2(MAX_SPRINGS);
    localparam int CNT_W       = SPR_AW + 1;
    localparam int NODE_W      = 8;
    localparam int NC_W        = 9;
    localparam int SPR_W       = 2 * NODE_W + 4 * 32;

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_MULT  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_CLEAR,
        OP_ADD,
        OP_WRX,
        OP_RDP,
        OP_RDP_DONE,
        OP_SP_RD,
        OP_SP_CHK,
        OP_XA,
        OP_XB,
        OP_DIFF,
        OP_DMUL,
        OP_ACC,
        OP_KMUL,
        OP_VAL,
        OP_TMUL,
        OP_TQ,
        OP_PR1,
        OP_PW1,
        OP_PR2,
        OP_PW2,
        OP_PUBLISH
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [1:0]        axis;
        logic [VEC_AW-1:0] clr_addr;
        logic [SPR_AW-1:0] spr_addr;
        logic              clear_input;
    } dp_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] total;
        logic             skip;
    } dp_sts_t;

    function automatic logic signed [31:0] q_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} - {b[31], b};
        if (s[32] != s[31])
            return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] q_fix(input logic signed [63:0] p);
        logic [16:0] top;
        top = p[63:47];
        if ((&top) || !(|top))
            return p[47:16];
        return p[63] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    endfunction

endpackage

### design/snhm_ram.sv
// ----------------------------------------------------------------------------
// snhm_ram
// Simple dual port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module snhm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/snhm_dpath.sv
// ----------------------------------------------------------------------------
// snhm_dpath
// Datapath: spring table, vector stores, shared multiplier, result registers.
// ----------------------------------------------------------------------------
module snhm_dpath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  snhm_pkg::dp_cmd_t     cmd,
    output snhm_pkg::dp_sts_t     sts,
    input  logic                  cfg_we,
    input  logic [8:0]            cfg_data,
    input  logic [7:0]            node_first,
    input  logic [7:0]            node_second,
    input  logic signed [31:0]    delta_x,
    input  logic signed [31:0]    delta_y,
    input  logic signed [31:0]    delta_z,
    input  logic signed [31:0]    stiffness,
    input  logic [9:0]            coord_index,
    input  logic signed [31:0]    coord_value,
    output logic [1:0]            status,
    output logic signed [31:0]    read_value,
    output logic [10:0]           spring_count
);
    import snhm_pkg::*;

    logic [NC_W-1:0]    node_count_reg, node_count_next;
    logic [CNT_W-1:0]   total_reg, total_next;

    logic [NODE_W-1:0]  n1_reg, n2_reg;
    logic signed [31:0] dx_reg, dy_reg, dz_reg, gain_reg, cval_reg;
    logic [VEC_AW-1:0]  idx_reg;

    logic signed [31:0] xa_reg, diff_reg, dot_reg, val_reg, t_reg;
    logic signed [63:0] prod_reg;
    logic [1:0]         res_status_reg;
    logic signed [31:0] res_value_reg;
    logic [1:0]         status_reg;
    logic signed [31:0] read_value_reg;
    logic [CNT_W-1:0]   count_reg;

    logic [SPR_W-1:0]   sp_rdata;
    logic [31:0]        in_rdata, pr_rdata;

    logic [NODE_W-1:0]  sp_n1, sp_n2;
    logic signed [31:0] sp_dx, sp_dy, sp_dz, sp_gain, d_sel;
    logic [VEC_AW-1:0]  a1, a2;
    logic [VEC_AW:0]    limit;
    logic               idx_ok, full, nodes_bad;

    logic               in_we, in_re, pr_we, pr_re, sp_we;
    logic [VEC_AW-1:0]  in_waddr, in_raddr, pr_waddr, pr_raddr;
    logic [31:0]        in_wdata, pr_wdata;
    logic signed [31:0] mul_a, mul_b;

    assign sp_n1   = sp_rdata[7:0];
    assign sp_n2   = sp_rdata[15:8];
    assign sp_dx   = sp_rdata[47:16];
    assign sp_dy   = sp_rdata[79:48];
    assign sp_dz   = sp_rdata[111:80];
    assign sp_gain = sp_rdata[143:112];

    always_comb
    begin
        case (cmd.axis)
            2'd0:    d_sel = sp_dx;
            2'd1:    d_sel = sp_dy;
            default: d_sel = sp_dz;
        endcase
    end

    assign a1 = ({2'b00, sp_n1} << 1) + {2'b00, sp_n1} + {8'd0, cmd.axis};
    assign a2 = ({2'b00, sp_n2} << 1) + {2'b00, sp_n2} + {8'd0, cmd.axis};

    assign limit     = ({1'b0, node_count_reg} << 1) + {1'b0, node_count_reg};
    assign idx_ok    = {1'b0, idx_reg} < limit;
    assign full      = total_reg >= CNT_W'(MAX_SPRINGS);
    assign nodes_bad = ({1'b0, n1_reg} >= node_count_reg) ||
                       ({1'b0, n2_reg} >= node_count_reg);

    assign sts.total = total_reg;
    assign sts.skip  = ({1'b0, sp_n1} >= node_count_reg) ||
                       ({1'b0, sp_n2} >= node_count_reg);

    assign sp_we = (cmd.op == OP_ADD) && !full && !nodes_bad;

    assign in_we    = ((cmd.op == OP_CLEAR) && cmd.clear_input) ||
                      ((cmd.op == OP_WRX) && idx_ok);
    assign in_waddr = (cmd.op == OP_CLEAR) ? cmd.clr_addr : idx_reg;
    assign in_wdata = (cmd.op == OP_CLEAR) ? 32'd0 : cval_reg;
    assign in_re    = (cmd.op == OP_XA) || (cmd.op == OP_XB);
    assign in_raddr = (cmd.op == OP_XA) ? a1 : a2;

    always_comb
    begin
        pr_we    = 1'b0;
        pr_waddr = cmd.clr_addr;
        pr_wdata = 32'd0;
        pr_re    = 1'b0;
        pr_raddr = idx_reg;
        case (cmd.op)
            OP_CLEAR:
            begin
                pr_we = 1'b1;
            end
            OP_PW1:
            begin
                pr_we    = 1'b1;
                pr_waddr = a1;
                pr_wdata = q_add(pr_rdata, t_reg);
            end
            OP_PW2:
            begin
                pr_we    = 1'b1;
                pr_waddr = a2;
                pr_wdata = q_sub(pr_rdata, t_reg);
            end
            OP_RDP:
            begin
                pr_re = 1'b1;
            end
            OP_PR1:
            begin
                pr_re    = 1'b1;
                pr_raddr = a1;
            end
            OP_PR2:
            begin
                pr_re    = 1'b1;
                pr_raddr = a2;
            end
            default:
            begin
                pr_re = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.op)
            OP_KMUL:
            begin
                mul_a = sp_gain;
                mul_b = dot_reg;
            end
            OP_TMUL:
            begin
                mul_a = d_sel;
                mul_b = val_reg;
            end
            default:
            begin
                mul_a = diff_reg;
                mul_b = d_sel;
            end
        endcase
    end

    snhm_ram #(.WIDTH(SPR_W), .DEPTH(MAX_SPRINGS)) u_spring_ram (
        .clk   (clk),
        .we    (sp_we),
        .waddr (total_reg[SPR_AW-1:0]),
        .wdata ({gain_reg, dz_reg, dy_reg, dx_reg, n2_reg, n1_reg}),
        .re    (cmd.op == OP_SP_RD),
        .raddr (cmd.spr_addr),
        .rdata (sp_rdata)
    );

    snhm_ram #(.WIDTH(32), .DEPTH(VEC_LEN)) u_input_ram (
        .clk   (clk),
        .we    (in_we),
        .waddr (in_waddr),
        .wdata (in_wdata),
        .re    (in_re),
        .raddr (in_raddr),
        .rdata (in_rdata)
    );

    snhm_ram #(.WIDTH(32), .DEPTH(VEC_LEN)) u_product_ram (
        .clk   (clk),
        .we    (pr_we),
        .waddr (pr_waddr),
        .wdata (pr_wdata),
        .re    (pr_re),
        .raddr (pr_raddr),
        .rdata (pr_rdata)
    );

    always_comb
    begin
        node_count_next = node_count_reg;
        if (cfg_we)
        begin
            node_count_next = (cfg_data > NC_W'(MAX_NODES)) ? NC_W'(MAX_NODES) : cfg_data;
        end
        total_next = total_reg;
        if (sp_we)
        begin
            total_next = total_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NC_W'(MAX_NODES);
            total_reg      <= '0;
        end
        else
        begin
            node_count_reg <= node_count_next;
            total_reg      <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                n1_reg         <= node_first;
                n2_reg         <= node_second;
                dx_reg         <= delta_x;
                dy_reg         <= delta_y;
                dz_reg         <= delta_z;
                gain_reg       <= stiffness;
                idx_reg        <= coord_index;
                cval_reg       <= coord_value;
                res_status_reg <= ST_OK;
                res_value_reg  <= '0;
            end
            OP_ADD:
            begin
                res_status_reg <= full ? ST_FULL : (nodes_bad ? ST_RANGE : ST_OK);
            end
            OP_WRX:
            begin
                res_status_reg <= idx_ok ? ST_OK : ST_RANGE;
            end
            OP_RDP_DONE:
            begin
                res_status_reg <= idx_ok ? ST_OK : ST_RANGE;
                res_value_reg  <= idx_ok ? pr_rdata : 32'd0;
            end
            OP_SP_CHK:
            begin
                dot_reg <= '0;
            end
            OP_XB:
            begin
                xa_reg <= in_rdata;
            end
            OP_DIFF:
            begin
                diff_reg <= q_sub(xa_reg, in_rdata);
            end
            OP_DMUL, OP_KMUL, OP_TMUL:
            begin
                prod_reg <= mul_a * mul_b;
            end
            OP_ACC:
            begin
                dot_reg <= q_add(dot_reg, q_fix(prod_reg));
            end
            OP_VAL:
            begin
                val_reg <= q_fix(prod_reg);
            end
            OP_TQ:
            begin
                t_reg <= q_fix(prod_reg);
            end
            OP_PUBLISH:
            begin
                status_reg     <= res_status_reg;
                read_value_reg <= res_value_reg;
                count_reg      <= total_reg;
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

    assign status       = status_reg;
    assign read_value   = read_value_reg;
    assign spring_count = count_reg;

endmodule

### design/snhm_ctrl.sv
// ----------------------------------------------------------------------------
// snhm_ctrl
// Controller: item handshake, clearing sweeps and the per-spring sequence.
// ----------------------------------------------------------------------------
module snhm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    output logic              out_valid,
    input  logic              out_stall,
    output snhm_pkg::dp_cmd_t cmd,
    input  snhm_pkg::dp_sts_t sts
);
    import snhm_pkg::*;

    typedef enum logic [4:0] {
        S_RST_CLR, S_IDLE, S_ADD, S_WRX, S_RDP, S_RDP_DONE, S_MCLR,
        S_SP_RD, S_SP_CHK, S_XA, S_XB, S_DIFF, S_DMUL, S_ACC, S_KMUL, S_VAL,
        S_TMUL, S_TQ, S_PR1, S_PW1, S_PR2, S_PW2, S_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [VEC_AW-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]  spr_reg, spr_next;
    logic [1:0]        axis_reg, axis_next;
    logic              out_valid_reg, out_valid_next;
    logic              publish, clr_last, spr_done;

    assign clr_last = clr_reg == VEC_AW'(VEC_LEN - 1);
    assign spr_done = spr_reg >= sts.total;
    assign publish  = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        spr_next       = spr_reg;
        axis_next      = axis_reg;
        out_valid_next = publish || (out_valid_reg && out_stall);
        cmd.op          = OP_NONE;
        cmd.axis        = axis_reg;
        cmd.clr_addr    = clr_reg;
        cmd.spr_addr    = spr_reg[SPR_AW-1:0];
        cmd.clear_input = 1'b0;
        unique case (state_reg)
            S_RST_CLR:
            begin
                cmd.op          = OP_CLEAR;
                cmd.clear_input = 1'b1;
                clr_next        = clr_reg + 1'b1;
                if (clr_last)
                begin
                    clr_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LATCH;
                    unique case (command)
                        CMD_ADD:   state_next = S_ADD;
                        CMD_WRITE: state_next = S_WRX;
                        CMD_MULT:  state_next = S_MCLR;
                        default:   state_next = S_RDP;
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.op     = OP_ADD;
                state_next = S_FINISH;
            end
            S_WRX:
            begin
                cmd.op     = OP_WRX;
                state_next = S_FINISH;
            end
            S_RDP:
            begin
                cmd.op     = OP_RDP;
                state_next = S_RDP_DONE;
            end
            S_RDP_DONE:
            begin
                cmd.op     = OP_RDP_DONE;
                state_next = S_FINISH;
            end
            S_MCLR:
            begin
                cmd.op   = OP_CLEAR;
                clr_next = clr_reg + 1'b1;
                if (clr_last)
                begin
                    clr_next   = '0;
                    spr_next   = '0;
                    state_next = S_SP_RD;
                end
            end
            S_SP_RD:
            begin
                if (spr_done)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = OP_SP_RD;
                    state_next = S_SP_CHK;
                end
            end
            S_SP_CHK:
            begin
                cmd.op    = OP_SP_CHK;
                axis_next = '0;
                if (sts.skip)
                begin
                    spr_next   = spr_reg + 1'b1;
                    state_next = S_SP_RD;
                end
                else
                begin
                    state_next = S_XA;
                end
            end
            S_XA:
            begin
                cmd.op     = OP_XA;
                state_next = S_XB;
            end
            S_XB:
            begin
                cmd.op     = OP_XB;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.op     = OP_DIFF;
                state_next = S_DMUL;
            end
            S_DMUL:
            begin
                cmd.op     = OP_DMUL;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.op = OP_ACC;
                if (axis_reg == 2'(AXES - 1))
                begin
                    axis_next  = '0;
                    state_next = S_KMUL;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_XA;
                end
            end
            S_KMUL:
            begin
                cmd.op     = OP_KMUL;
                state_next = S_VAL;
            end
            S_VAL:
            begin
                cmd.op     = OP_VAL;
                state_next = S_TMUL;
            end
            S_TMUL:
            begin
                cmd.op     = OP_TMUL;
                state_next = S_TQ;
            end
            S_TQ:
            begin
                cmd.op     = OP_TQ;
                state_next = S_PR1;
            end
            S_PR1:
            begin
                cmd.op     = OP_PR1;
                state_next = S_PW1;
            end
            S_PW1:
            begin
                cmd.op     = OP_PW1;
                state_next = S_PR2;
            end
            S_PR2:
            begin
                cmd.op     = OP_PR2;
                state_next = S_PW2;
            end
            S_PW2:
            begin
                cmd.op = OP_PW2;
                if (axis_reg == 2'(AXES - 1))
                begin
                    spr_next   = spr_reg + 1'b1;
                    state_next = S_SP_RD;
                end
                else
                begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = S_TMUL;
                end
            end
            S_FINISH:
            begin
                if (publish)
                begin
                    cmd.op     = OP_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RST_CLR;
            clr_reg       <= '0;
            spr_reg       <= '0;
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            spr_reg       <= spr_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

### design/spring_network_hessian_matvec_unit.sv
// ----------------------------------------------------------------------------
// spring_network_hessian_matvec_unit
// Matrix-free spring network Hessian times coordinate vector, signed Q16.16.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid/in_stall, one result item leaves on
// out_valid/out_stall for every input item. node_count is written on the
// cfg_valid/cfg_ready port, which is always ready; the user must write it
// only while the unit is idle, as the block itself does not enforce that.
// Add-spring and write-element items pass S_ADD or S_WRX, read-element
// items S_RDP and S_RDP_DONE (one registered RAM read), before S_FINISH
// loads the result register; the next item is accepted once the controller
// is back in S_IDLE. A multiply item first sweeps the 768-entry product
// RAM, then walks the spring table through one shared 32x32 multiplier and
// the single ports of the vector RAMs. One item is in work at a time.
// After reset the unit runs a clearing pass over all 768 entries of both
// vector RAMs with in_stall high; the spring table starts empty.
// A result held by out_stall stays in the output register; the next item is
// still accepted and runs until its own result is ready, then waits.
// ----------------------------------------------------------------------------
module spring_network_hessian_matvec_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [7:0]         node_first,
    input  logic [7:0]         node_second,
    input  logic signed [31:0] delta_x,
    input  logic signed [31:0] delta_y,
    input  logic signed [31:0] delta_z,
    input  logic signed [31:0] stiffness,
    input  logic [9:0]         coord_index,
    input  logic signed [31:0] coord_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] read_value,
    output logic [10:0]        spring_count,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [8:0]         cfg_data
);
    import snhm_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    snhm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    snhm_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .node_first   (node_first),
        .node_second  (node_second),
        .delta_x      (delta_x),
        .delta_y      (delta_y),
        .delta_z      (delta_z),
        .stiffness    (stiffness),
        .coord_index  (coord_index),
        .coord_value  (coord_value),
        .status       (status),
        .read_value   (read_value),
        .spring_count (spring_count)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> spring_count <= 11'(MAX_SPRINGS))
        else $error("spring count beyond table size");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_FULL) |-> spring_count == 11'(MAX_SPRINGS))
        else $error("table full reported with free entries");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> read_value == 32'sd0)
        else $error("rejected item returned data");

endmodule

### verif/tb_spring_network_hessian_matvec_unit.sv
// ----------------------------------------------------------------------------
// tb_spring_network_hessian_matvec_unit
// Self-checking bench for the spring network Hessian product unit: a queued
// driver with random gaps, a stalling monitor, and a bit-exact Q16.16
// predictor of the spring table, coordinate vector and product store.
// ----------------------------------------------------------------------------
module tb_spring_network_hessian_matvec_unit;
    import snhm_pkg::*;

    typedef struct packed {
        logic [1:0]         command;
        logic [7:0]         node_first;
        logic [7:0]         node_second;
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] delta_z;
        logic signed [31:0] stiffness;
        logic [9:0]         coord_index;
        logic signed [31:0] coord_value;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [10:0]        spring_count;
    } answer_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         command;
    logic [7:0]         node_first;
    logic [7:0]         node_second;
    logic signed [31:0] delta_x;
    logic signed [31:0] delta_y;
    logic signed [31:0] delta_z;
    logic signed [31:0] stiffness;
    logic [9:0]         coord_index;
    logic signed [31:0] coord_value;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [10:0]        spring_count;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [8:0]         cfg_data;

    spring_network_hessian_matvec_unit dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .node_first(node_first), .node_second(node_second),
        .delta_x(delta_x), .delta_y(delta_y), .delta_z(delta_z),
        .stiffness(stiffness), .coord_index(coord_index),
        .coord_value(coord_value), .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .read_value(read_value), .spring_count(spring_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predictor state
    logic [7:0]         tbl_n1 [MAX_SPRINGS];
    logic [7:0]         tbl_n2 [MAX_SPRINGS];
    logic signed [31:0] tbl_dx [MAX_SPRINGS];
    logic signed [31:0] tbl_dy [MAX_SPRINGS];
    logic signed [31:0] tbl_dz [MAX_SPRINGS];
    logic signed [31:0] tbl_k  [MAX_SPRINGS];
    int                 stored_springs = 0;
    logic signed [31:0] coords [VEC_LEN];
    logic signed [31:0] hx     [VEC_LEN];
    int                 nodes_in_use = MAX_NODES;

    cmd_item_t pending_items[$];
    answer_t   expected_answers[$];
    int        mismatches = 0;
    int        answers_seen = 0;
    int        items_queued = 0;
    int        idle_cycles;
    int        in_gap;
    int        out_gap;

    function automatic logic signed [31:0] sat(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        longint p;
        p = longint'(a) * longint'(b);
        return sat(p >>> 16);
    endfunction

    function automatic logic signed [31:0] fx_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return sat(longint'(a) + longint'(b));
    endfunction

    function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        return sat(longint'(a) - longint'(b));
    endfunction

    function automatic void apply_spring_product();
        int                 a;
        int                 b;
        logic signed [31:0] d [3];
        logic signed [31:0] dot;
        logic signed [31:0] v;
        logic signed [31:0] t;
        for (int i = 0; i < VEC_LEN; i++)
            hx[i] = '0;
        for (int s = 0; s < stored_springs; s++)
        begin
            a = int'(tbl_n1[s]);
            b = int'(tbl_n2[s]);
            if (a >= nodes_in_use || b >= nodes_in_use)
                continue;
            d[0] = tbl_dx[s];
            d[1] = tbl_dy[s];
            d[2] = tbl_dz[s];
            dot = '0;
            for (int c = 0; c < 3; c++)
                dot = fx_add(dot, fx_mul(fx_sub(coords[3*a+c], coords[3*b+c]), d[c]));
            v = fx_mul(tbl_k[s], dot);
            for (int c = 0; c < 3; c++)
            begin
                t = fx_mul(d[c], v);
                hx[3*a+c] = fx_add(hx[3*a+c], t);
                hx[3*b+c] = fx_sub(hx[3*b+c], t);
            end
        end
    endfunction

    function automatic answer_t predict_answer(input cmd_item_t it);
        answer_t r;
        int      lim;
        lim = 3 * nodes_in_use;
        r = '0;
        case (it.command)
            CMD_ADD:
                if (stored_springs >= MAX_SPRINGS)
                    r.status = ST_FULL;
                else if (it.node_first >= nodes_in_use || it.node_second >= nodes_in_use)
                    r.status = ST_RANGE;
                else
                begin
                    tbl_n1[stored_springs] = it.node_first;
                    tbl_n2[stored_springs] = it.node_second;
                    tbl_dx[stored_springs] = it.delta_x;
                    tbl_dy[stored_springs] = it.delta_y;
                    tbl_dz[stored_springs] = it.delta_z;
                    tbl_k[stored_springs]  = it.stiffness;
                    stored_springs++;
                end
            CMD_WRITE:
                if (it.coord_index >= lim)
                    r.status = ST_RANGE;
                else
                    coords[it.coord_index] = it.coord_value;
            CMD_MULT:
                apply_spring_product();
            default:
                if (it.coord_index >= lim)
                    r.status = ST_RANGE;
                else
                    r.read_value = hx[it.coord_index];
        endcase
        r.spring_count = stored_springs[10:0];
        return r;
    endfunction

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 5))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return $urandom;
            3:       return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
        endcase
    endfunction

    function automatic cmd_item_t make_item(input logic [1:0] cmd, input int nmax);
        cmd_item_t it;
        it.command     = cmd;
        it.node_first  = ($urandom_range(0, 15) == 0) ? 8'($urandom) :
                         8'($urandom_range(0, nmax - 1));
        it.node_second = ($urandom_range(0, 15) == 0) ? 8'($urandom) :
                         8'($urandom_range(0, nmax - 1));
        it.delta_x     = rand_q();
        it.delta_y     = rand_q();
        it.delta_z     = rand_q();
        it.stiffness   = rand_q();
        it.coord_index = ($urandom_range(0, 15) == 0) ? 10'($urandom) :
                         10'($urandom_range(0, 3 * nmax - 1));
        it.coord_value = rand_q();
        return it;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void queue_item(input cmd_item_t it);
        pending_items.insert(pending_items.size(), it);
        items_queued++;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            command     <= CMD_ADD;
            node_first  <= '0;
            node_second <= '0;
            delta_x     <= '0;
            delta_y     <= '0;
            delta_z     <= '0;
            stiffness   <= '0;
            coord_index <= '0;
            coord_value <= '0;
            in_gap      <= 0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (in_valid)
                expected_answers.insert(expected_answers.size(),
                    predict_answer({command, node_first, node_second, delta_x,
                    delta_y, delta_z, stiffness, coord_index, coord_value}));
            if (in_gap > 0 || pending_items.size() == 0)
            begin
                in_valid <= 1'b0;
                if (in_gap > 0)
                    in_gap <= in_gap - 1;
            end
            else
            begin
                in_valid <= 1'b1;
                {command, node_first, node_second, delta_x, delta_y, delta_z,
                 stiffness, coord_index, coord_value} <= pending_items.pop_front();
                in_gap <= draw_gap();
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                answers_seen++;
                if (expected_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d value %0d count %0d",
                                 status, read_value, spring_count);
                end
                else
                begin
                    answer_t e;
                    e = expected_answers.pop_front();
                    if (e.status !== status || e.read_value !== read_value ||
                        e.spring_count !== spring_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch #%0d: status %0d/%0d value %0d/%0d count %0d/%0d",
                                     answers_seen, e.status, status, e.read_value,
                                     read_value, e.spring_count, spring_count);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap   <= out_gap - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    out_gap <= draw_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 200000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic drain();
        while (answers_seen < items_queued)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_nodes(input logic [8:0] v);
        drain();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        nodes_in_use = (int'(v) > MAX_NODES) ? MAX_NODES : int'(v);
    endtask

    task automatic run_phase(input int count, input int nmax);
        cmd_item_t it;
        for (int i = 0; i < count; i++)
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 25)
                it = make_item(CMD_ADD, nmax);
            else if (r < 60)
                it = make_item(CMD_WRITE, nmax);
            else if (r < 65)
                it = make_item(CMD_MULT, nmax);
            else
                it = make_item(CMD_READ, nmax);
            queue_item(it);
        end
    endtask

    initial
    begin
        cmd_item_t it;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        for (int i = 0; i < VEC_LEN; i++)
        begin
            coords[i] = '0;
            hx[i]     = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: small network, extremes, stale springs, range errors
        set_nodes(9'd4);
        it = make_item(CMD_WRITE, 4);
        for (int i = 0; i < 12; i += 3)
        begin
            it.coord_index = 10'(i);
            it.coord_value = (i == 0) ? 32'sh7fff_ffff : (i == 3) ? 32'sh8000_0000 : 32'sh0001_0000;
            queue_item(it);
        end
        it.coord_index = 10'd12;
        queue_item(it);
        it.coord_index = 10'h3ff;
        queue_item(it);
        it = make_item(CMD_ADD, 4);
        it.node_first = 8'd0; it.node_second = 8'd1;
        it.delta_x = 32'sh7fff_ffff; it.delta_y = 32'sh8000_0000; it.stiffness = 32'sh0001_0000;
        queue_item(it);
        it.node_first = 8'd2; it.node_second = 8'd2;
        queue_item(it);
        it.node_first = 8'd3; it.node_second = 8'd255;
        queue_item(it);
        it.node_first = 8'd255; it.node_second = 8'd0;
        it.delta_x = 32'sh0001_8000; it.stiffness = 32'sh8000_0000;
        queue_item(it);
        it.node_first = 8'd3; it.node_second = 8'd1;
        queue_item(it);
        it.command = CMD_MULT;
        queue_item(it);
        for (int i = 0; i < 5; i++)
        begin
            it = make_item(CMD_READ, 4);
            it.coord_index = (i == 4) ? 10'd12 : 10'(3 * i);
            queue_item(it);
        end
        set_nodes(9'd2);
        it.command = CMD_MULT;
        queue_item(it);
        it.command = CMD_READ; it.coord_index = 10'd0;
        queue_item(it);
        set_nodes(9'd0);
        it = make_item(CMD_ADD, 1);
        queue_item(it);
        it.command = CMD_READ;
        queue_item(it);

        // random phases across settings, including the top and above it
        set_nodes(9'd8);
        run_phase(300, 8);
        set_nodes(9'd511);
        run_phase(250, 256);
        set_nodes(9'd256);
        run_phase(200, 256);
        set_nodes(9'd1);
        run_phase(30, 1);
        set_nodes(9'd3);
        run_phase(150, 3);
        drain();

        $display("covered %0d results over node counts 0..511, springs stored %0d",
                 answers_seen, stored_springs);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

### sim.f
design/snhm_pkg.sv
design/snhm_ram.sv
design/snhm_dpath.sv
design/snhm_ctrl.sv
design/spring_network_hessian_matvec_unit.sv
verif/tb_spring_network_hessian_matvec_unit.sv
